/* design/ppik_pkg.sv */
// Package with shared types, codes and the key position table.
`timescale 1ns / 1ps
package ppik_pkg;

    // Kinds of input transfer.
    localparam logic [1:0] ACT_KEY   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // Port numbers.
    localparam logic [1:0] PORT_SLOT   = 2'd0;
    localparam logic [1:0] PORT_MATRIX = 2'd1;
    localparam logic [1:0] PORT_C      = 2'd2;
    localparam logic [1:0] PORT_CTRL   = 2'd3;

    localparam logic [7:0] BYTE_ONES = 8'hff;

    // One accepted input item.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] key_code;
        logic [1:0] port_select;
        logic [7:0] write_data;
    } cmd_t;

    // Position of a host key in the matrix: high nibble is row plus one,
    // low nibble is the column. Zero means the key is not wired.
    function automatic logic [7:0] key_position(input logic [6:0] idx);
        logic [7:0] pos;
        case (idx)
            7'd1:  pos = 8'h11;
            7'd2:  pos = 8'h12;
            7'd3:  pos = 8'h13;
            7'd4:  pos = 8'h14;
            7'd5:  pos = 8'h15;
            7'd6:  pos = 8'h16;
            7'd7:  pos = 8'h17;
            7'd8:  pos = 8'h20;
            7'd9:  pos = 8'h21;
            7'd10: pos = 8'h10;
            7'd15: pos = 8'h56;
            7'd16: pos = 8'h64;
            7'd17: pos = 8'h42;
            7'd18: pos = 8'h57;
            7'd19: pos = 8'h61;
            7'd20: pos = 8'h66;
            7'd21: pos = 8'h62;
            7'd22: pos = 8'h46;
            7'd23: pos = 8'h54;
            7'd24: pos = 8'h55;
            7'd26: pos = 8'h87;
            7'd29: pos = 8'h36;
            7'd30: pos = 8'h60;
            7'd31: pos = 8'h41;
            7'd32: pos = 8'h43;
            7'd33: pos = 8'h44;
            7'd34: pos = 8'h45;
            7'd35: pos = 8'h47;
            7'd36: pos = 8'h50;
            7'd37: pos = 8'h51;
            7'd38: pos = 8'h27;
            7'd43: pos = 8'h67;
            7'd44: pos = 8'h65;
            7'd45: pos = 8'h40;
            7'd46: pos = 8'h63;
            7'd47: pos = 8'h37;
            7'd48: pos = 8'h53;
            7'd49: pos = 8'h52;
            7'd50: pos = 8'h32;
            7'd51: pos = 8'h33;
            7'd52: pos = 8'h34;
            7'd55: pos = 8'h90;
            default: pos = 8'h00;
        endcase
        return pos;
    endfunction

endpackage

/* design/ppik_key_matrix.sv */
// Key matrix storage with key event update and row readout.
`timescale 1ns / 1ps
module ppik_key_matrix #(
    parameter int MATRIX_ROWS = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  ppik_pkg::cmd_t cmd,
    input  logic [3:0]    row_sel,
    output logic [7:0]    row_data
);
    import ppik_pkg::*;

    logic [7:0] matrix_reg  [MATRIX_ROWS];
    logic [7:0] matrix_next [MATRIX_ROWS];
    logic [7:0] entry;
    logic [3:0] entry_row;
    logic       hit;

    assign entry     = key_position(cmd.key_code[6:0]);
    assign entry_row = entry[7:4] - 4'd1;
    // The row must exist and the column must be a bit of the byte.
    assign hit = step && (cmd.action == ACT_KEY) && (entry[7:4] != 4'd0)
                 && ((5'(entry[7:4]) - 5'd1) < 5'(MATRIX_ROWS)) && !entry[3];

    always_comb begin
        for (int r = 0; r < MATRIX_ROWS; r++) begin
            matrix_next[r] = matrix_reg[r];
            if (hit && entry_row == 4'(r)) begin
                matrix_next[r][entry[2:0]] = !cmd.key_code[7];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int r = 0; r < MATRIX_ROWS; r++) begin
            if (!aresetn) begin
                matrix_reg[r] <= '0;
            end else begin
                matrix_reg[r] <= matrix_next[r];
            end
        end
    end

    // Rows read active low; a select past the last row reads all ones.
    always_comb begin
        row_data = BYTE_ONES;
        for (int r = 0; r < MATRIX_ROWS; r++) begin
            if (row_sel == 4'(r)) begin
                row_data = ~matrix_reg[r];
            end
        end
    end

endmodule

/* design/ppik_port_regs.sv */
// Slot and port C registers, port writes and the port read selection.
`timescale 1ns / 1ps
module ppik_port_regs (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  ppik_pkg::cmd_t cmd,
    input  logic [7:0]     row_data,
    output logic [7:0]     port_c,
    output logic [7:0]     read_data
);
    import ppik_pkg::*;

    logic [7:0] slot_reg, slot_next;
    logic [7:0] port_c_reg, port_c_next;

    always_comb begin
        slot_next   = slot_reg;
        port_c_next = port_c_reg;
        if (step && cmd.action == ACT_WRITE) begin
            unique case (cmd.port_select)
                PORT_SLOT:   slot_next   = cmd.write_data;
                PORT_C:      port_c_next = cmd.write_data;
                PORT_CTRL: begin
                    // Bit set/reset command; mode writes have bit 7 set.
                    if (!cmd.write_data[7]) begin
                        port_c_next[cmd.write_data[3:1]] = cmd.write_data[0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= '0;
            port_c_reg <= '0;
        end else begin
            slot_reg   <= slot_next;
            port_c_reg <= port_c_next;
        end
    end

    assign port_c = port_c_reg;

    always_comb begin
        unique case (cmd.port_select)
            PORT_SLOT:   read_data = slot_reg;
            PORT_MATRIX: read_data = row_data;
            PORT_C:      read_data = port_c_reg;
            default:     read_data = BYTE_ONES;
        endcase
    end

endmodule

/* design/ppi_keyboard_matrix_top.sv */
// Top level of the parallel port interface with a scanned key matrix.
`timescale 1ns / 1ps
// Usage: each slave-side transfer carries one command. s_tuser holds the
// kind (key event, port read or port write); s_tdata holds the key code,
// the port number and the write byte. Key events set or clear one bit of
// the key matrix through a fixed position table. Port writes load the
// slot register or port C, or set/reset one port C bit. Only port reads
// give a result: one master-side transfer whose tdata is the read byte.
// A command is captured in an input register and is executed from there
// by short logic that updates the state and loads the result register,
// so a read result passes through the input register and the result
// register before it is presented on the master side.
// One command can be taken every cycle. When the receiver stalls with a
// result waiting, a pending read holds in the input register and s_tready
// drops; key events and writes behind no waiting read keep flowing.
// Reset clears the key matrix (no key down), the slot register, port C
// and both valid flags; it needs no clearing pass.
// s_tready stays low while reset is asserted.
module ppi_keyboard_matrix_top #(
    parameter int MATRIX_ROWS = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // key_code[7:0], port_select[9:8],
                                  // write_data[17:10], zero [23:18]
    input  logic [1:0]  s_tuser,  // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // read_data[7:0]
);
    import ppik_pkg::*;

    cmd_t       cmd_reg;
    logic       in_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_valid_reg;

    logic       out_free;
    logic       is_read;
    logic       step;
    logic [7:0] row_data;
    logic [7:0] port_c;
    logic [7:0] read_data;

    assign out_free = !out_valid_reg || m_tready;
    assign is_read  = (cmd_reg.action == ACT_READ);
    // The held command executes unless it is a read with nowhere to go.
    assign step     = in_valid_reg && (!is_read || out_free);
    assign s_tready = aresetn && (!in_valid_reg || step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg.action      <= s_tuser;
            cmd_reg.key_code    <= s_tdata[7:0];
            cmd_reg.port_select <= s_tdata[9:8];
            cmd_reg.write_data  <= s_tdata[17:10];
        end
    end

    ppik_key_matrix #(
        .MATRIX_ROWS(MATRIX_ROWS)
    ) u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cmd     (cmd_reg),
        .row_sel (port_c[3:0]),
        .row_data(row_data)
    );

    ppik_port_regs u_ports (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .cmd      (cmd_reg),
        .row_data (row_data),
        .port_c   (port_c),
        .read_data(read_data)
    );

    // Result register: loaded by an executing read, freed by a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && is_read;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && is_read) begin
            out_data_reg <= read_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
